>>> rtl/core/lkp3_pkg.sv
// lkp3_pkg: shared types, constants and helpers for the lookup3 byte hash.
// Used by lkp3_front, lkp3_queue, lkp3_back and lookup3_byte_hash.
`timescale 1ns / 1ps
`default_nettype none

package lkp3_pkg;

    localparam logic [31:0] SEED_GOLDEN = 32'h9e37_79b9;
    localparam logic [31:0] SEED_EXTRA  = 32'd3923095;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One unit of work for the mixing datapath
    typedef struct packed {
        logic        first;     // load the seed before adding the words
        logic [31:0] seed;
        logic        do_mix;    // full 12-byte group: add words, then mix
        logic        do_fin;    // key ends: (add tail words), final mix, emit
        logic [31:0] k0;
        logic [31:0] k1;
        logic [31:0] k2;
        logic        mismatch;
    } t_job;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] dbl;
        dbl = {x, x} << n;
        return dbl[63:32];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/lkp3_front.sv
// lkp3_front: takes key bytes, packs them into 12-byte groups and tail words,
// tracks the declared length, and pushes jobs into the queue. Uses lkp3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lkp3_front import lkp3_pkg::*; #(
    parameter int MAX_KEY_BYTES = 4095
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_key_byte,
    input  wire logic        i_byte_present,
    input  wire logic [11:0] i_key_length,
    input  wire logic        i_last_item,
    output t_job             o_job,
    output logic             o_push
);

    localparam int RW = $clog2(MAX_KEY_BYTES + 1);
    localparam int CW = (RW > 12) ? RW : 12;

    logic          r_active, n_active;
    logic [3:0]    r_pos, n_pos;
    logic [31:0]   r_w0, n_w0;
    logic [31:0]   r_w1, n_w1;
    logic [23:0]   r_held, n_held;
    logic [RW-1:0] r_remain, n_remain;
    logic          r_ovr, n_ovr;
    logic          r_pend, n_pend;
    logic [31:0]   r_seed, n_seed;

    logic [CW-1:0] decl_c;
    logic [31:0]   byte_sh;
    logic          group_done;

    always_comb begin
        if (CW'(i_key_length) > CW'(MAX_KEY_BYTES)) begin
            decl_c = CW'(MAX_KEY_BYTES);
        end else begin
            decl_c = CW'(i_key_length);
        end
    end

    always_comb begin
        n_active = r_active;
        n_pos    = r_pos;
        n_w0     = r_w0;
        n_w1     = r_w1;
        n_held   = r_held;
        n_remain = r_remain;
        n_ovr    = r_ovr;
        n_pend   = r_pend;
        n_seed   = r_seed;
        group_done = 1'b0;
        o_job    = '0;

        // first item of a key reseeds everything
        if (!r_active) begin
            n_active = 1'b1;
            n_pos    = '0;
            n_w0     = '0;
            n_w1     = '0;
            n_held   = '0;
            n_remain = decl_c[RW-1:0];
            n_ovr    = 1'b0;
            n_pend   = 1'b1;
            n_seed   = SEED_GOLDEN + SEED_EXTRA + 32'(decl_c);
        end

        byte_sh = 32'(i_key_byte) << {n_pos[1:0], 3'b000};

        o_job.k0 = n_w0;
        o_job.k1 = n_w1;
        o_job.k2 = {n_held, i_key_byte};

        if (i_byte_present) begin
            if (n_remain != '0) begin
                n_remain = n_remain - RW'(1);
            end else begin
                n_ovr = 1'b1;
            end
            if (n_pos < 4'd4) begin
                n_w0  = n_w0 | byte_sh;
                n_pos = n_pos + 4'd1;
            end else if (n_pos < 4'd8) begin
                n_w1  = n_w1 | byte_sh;
                n_pos = n_pos + 4'd1;
            end else if (n_pos < 4'd11) begin
                n_held = n_held | byte_sh[23:0];
                n_pos  = n_pos + 4'd1;
            end else begin
                // group complete; c word is bytes 8..11
                group_done = 1'b1;
                o_job.k0 = n_w0;
                o_job.k1 = n_w1;
                o_job.k2 = {i_key_byte, n_held};
                n_w0   = '0;
                n_w1   = '0;
                n_held = '0;
                n_pos  = '0;
            end
        end

        // tail: bytes 8..10 go one byte higher in c
        if (!group_done) begin
            o_job.k0 = n_w0;
            o_job.k1 = n_w1;
            o_job.k2 = {n_held, 8'h00};
        end

        o_job.first    = n_pend;
        o_job.seed     = n_seed;
        o_job.do_mix   = group_done;
        o_job.do_fin   = i_last_item;
        o_job.mismatch = (n_remain != '0) || n_ovr;

        o_push = i_accept && (group_done || i_last_item);
        if (group_done || i_last_item) begin
            n_pend = 1'b0;
        end
        if (i_last_item) begin
            n_active = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pos    <= '0;
            r_remain <= '0;
            r_ovr    <= 1'b0;
            r_pend   <= 1'b0;
        end else if (i_accept) begin
            r_active <= n_active;
            r_pos    <= n_pos;
            r_remain <= n_remain;
            r_ovr    <= n_ovr;
            r_pend   <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_w0   <= n_w0;
            r_w1   <= n_w1;
            r_held <= n_held;
            r_seed <= n_seed;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/lkp3_queue.sv
// lkp3_queue: short job queue between the byte front end and the mixer.
// Register based, depth from lkp3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lkp3_queue import lkp3_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_empty,
    output logic      o_full
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("job queue underflow");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("job queue count out of range");
`endif

endmodule

`default_nettype wire

>>> rtl/core/lkp3_back.sv
// lkp3_back: lookup3 mixing datapath. One mix or final row per cycle on the
// a/b/c words, except that a stalled output holds the last final row; result held in an output register. Uses lkp3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lkp3_back import lkp3_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_job        i_job,
    input  wire logic        i_empty,
    output logic             o_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_hash_value,
    output logic             o_length_mismatch
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MIX,
        S_FIN
    } t_state;

    localparam logic [2:0] MIX_LAST = 3'd5;
    localparam logic [2:0] FIN_LAST = 3'd6;

    t_state      r_state, n_state;
    logic [2:0]  r_row, n_row;
    logic [31:0] r_a, n_a;
    logic [31:0] r_b, n_b;
    logic [31:0] r_c, n_c;
    t_job        r_job, n_job;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_hash, n_hash;
    logic        r_mis, n_mis;

    logic        out_free;
    logic [31:0] base_a, base_b, base_c;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_job       = r_job;
        n_out_valid = r_out_valid;
        n_hash      = r_hash;
        n_mis       = r_mis;
        o_pop       = 1'b0;

        base_a = i_job.first ? i_job.seed : r_a;
        base_b = i_job.first ? i_job.seed : r_b;
        base_c = i_job.first ? i_job.seed : r_c;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_job = i_job;
                    n_a   = base_a + i_job.k0;
                    n_b   = base_b + i_job.k1;
                    n_c   = base_c + i_job.k2;
                    n_row = '0;
                    if (i_job.do_mix) begin
                        n_state = S_MIX;
                    end else if (i_job.do_fin) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_MIX: begin
                case (r_row)
                    3'd0: begin
                        n_a = (r_a - r_c) ^ rotl32(r_c, 5'd4);
                        n_c = r_c + r_b;
                    end
                    3'd1: begin
                        n_b = (r_b - r_a) ^ rotl32(r_a, 5'd6);
                        n_a = r_a + r_c;
                    end
                    3'd2: begin
                        n_c = (r_c - r_b) ^ rotl32(r_b, 5'd8);
                        n_b = r_b + r_a;
                    end
                    3'd3: begin
                        n_a = (r_a - r_c) ^ rotl32(r_c, 5'd16);
                        n_c = r_c + r_b;
                    end
                    3'd4: begin
                        n_b = (r_b - r_a) ^ rotl32(r_a, 5'd19);
                        n_a = r_a + r_c;
                    end
                    3'd5: begin
                        n_c = (r_c - r_b) ^ rotl32(r_b, 5'd4);
                        n_b = r_b + r_a;
                    end
                    default: begin
                    end
                endcase
                if (r_row == MIX_LAST) begin
                    n_row   = '0;
                    // a group closed by the last byte has an empty tail
                    n_state = r_job.do_fin ? S_FIN : S_IDLE;
                end else begin
                    n_row = r_row + 3'd1;
                end
            end
            S_FIN: begin
                case (r_row)
                    3'd0: n_c = (r_c ^ r_b) - rotl32(r_b, 5'd14);
                    3'd1: n_a = (r_a ^ r_c) - rotl32(r_c, 5'd11);
                    3'd2: n_b = (r_b ^ r_a) - rotl32(r_a, 5'd25);
                    3'd3: n_c = (r_c ^ r_b) - rotl32(r_b, 5'd16);
                    3'd4: n_a = (r_a ^ r_c) - rotl32(r_c, 5'd4);
                    3'd5: n_b = (r_b ^ r_a) - rotl32(r_a, 5'd14);
                    3'd6: n_c = (r_c ^ r_b) - rotl32(r_b, 5'd24);
                    default: begin
                    end
                endcase
                if (r_row == FIN_LAST) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_hash      = n_c;
                        n_mis       = r_job.mismatch;
                        n_row       = '0;
                        n_state     = S_IDLE;
                    end else begin
                        n_c = r_c;
                    end
                end else begin
                    n_row = r_row + 3'd1;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_row   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
        end
        r_a    <= n_a;
        r_b    <= n_b;
        r_c    <= n_c;
        r_job  <= n_job;
        r_hash <= n_hash;
        r_mis  <= n_mis;
    end

    assign o_out_valid       = r_out_valid;
    assign o_hash_value      = r_hash;
    assign o_length_mismatch = r_mis;

`ifndef ASSERT_OFF
    a_mix_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MIX) |-> (r_row <= MIX_LAST))
        else $error("mix row counter out of range");
    a_fin_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (r_row <= FIN_LAST))
        else $error("final row counter out of range");
    a_idle_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_row == '0))
        else $error("row counter not cleared in idle");
`endif

endmodule

`default_nettype wire

>>> rtl/core/lookup3_byte_hash.sv
// lookup3_byte_hash: streaming 32-bit lookup3 hash of a byte key.
// Instantiates lkp3_front, lkp3_queue and lkp3_back; uses lkp3_pkg.
//
// Input channel (i_in_valid / o_in_stall): one key byte per item, in order.
// key_length is sampled on the first item of a key; last_item ends the key.
// An item with byte_present low and last_item high hashes an empty key.
// Output channel (o_out_valid / i_out_stall): one hash and a length
// mismatch flag per key, in key order.
// Throughput: one byte per cycle while o_in_stall is low. The mixer loads
// each job, then runs the mix rows for a completed 12-byte group and the
// final rows for a key end, so it can fall behind on short keys; the
// 2-entry job queue absorbs the difference until it fills and o_in_stall
// rises. The hash follows the queue, the load, the mix rows when the last
// byte closes a group, and the final rows, after any job queued ahead.
// A stalled result sits in the output register; the mixer then holds its
// last final row, while the front keeps taking bytes until the queue fills.
// Reset (i_rst_n low, synchronous) drops any partial key and queued jobs.
`timescale 1ns / 1ps
`default_nettype none

module lookup3_byte_hash import lkp3_pkg::*; #(
    parameter int MAX_KEY_BYTES = 4095
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_key_byte,
    input  wire logic        i_byte_present,
    input  wire logic [11:0] i_key_length,
    input  wire logic        i_last_item,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_hash_value,
    output logic             o_length_mismatch
);

    t_job push_job;
    t_job head_job;
    logic push;
    logic pop;
    logic q_empty;
    logic q_full;
    logic accept;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    lkp3_front #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_key_byte     (i_key_byte),
        .i_byte_present (i_byte_present),
        .i_key_length   (i_key_length),
        .i_last_item    (i_last_item),
        .o_job          (push_job),
        .o_push         (push)
    );

    lkp3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    lkp3_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_job             (head_job),
        .i_empty           (q_empty),
        .o_pop             (pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_hash_value      (o_hash_value),
        .o_length_mismatch (o_length_mismatch)
    );

endmodule

`default_nettype wire
